// ----- rtl/dxt_pkg.sv -----
// shared types, constants and helper functions of the texel decoder
// no dependencies; imported by dxt_recip_div, dxt_texel_decoder_top and tb
package dxt_pkg;

	// format codes on the mode input
	localparam logic [1:0] MODE_DXT1 = 2'd0;
	localparam logic [1:0] MODE_DXT3 = 2'd1;
	localparam logic [1:0] MODE_DXT5 = 2'd2;

	// divisor applied in the last stage
	typedef enum logic [1:0] {
		DIV_NONE = 2'd0,
		DIV_3    = 2'd1,
		DIV_5    = 2'd2,
		DIV_7    = 2'd3
	} div_kind_t;

	// reciprocal constants and shifts, exact over the numerator ranges used here
	localparam logic [9:0]  RECIP3  = 10'd683;
	localparam logic [10:0] RECIP5  = 11'd1639;
	localparam logic [11:0] RECIP7  = 12'd2341;

	// v * 255 / 31 truncated, as 8v + floor(7v / 31)
	function automatic logic [7:0] expand5(input logic [4:0] v);
		logic [2:0] k;
		begin
			k = 3'(v >= 5'd5) + 3'(v >= 5'd9) + 3'(v >= 5'd14) + 3'(v >= 5'd18)
				+ 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v >= 5'd31);
			return {v, 3'b000} + {5'd0, k};
		end
	endfunction

	// v * 255 / 63 truncated, as 4v + floor(v / 21)
	function automatic logic [7:0] expand6(input logic [5:0] v);
		logic [1:0] k;
		begin
			k = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
			return {v, 2'b00} + {6'd0, k};
		end
	endfunction

endpackage

// ----- rtl/dxt_recip_div.sv -----
// small constant divider: numerator / 3, 5 or 7 by reciprocal multiply, or pass-through
// depends on dxt_pkg
module dxt_recip_div import dxt_pkg::*; (
	input  logic [10:0] num,
	input  div_kind_t   kind,
	output logic [7:0]  quot
);

	logic [20:0] prod3;
	logic [21:0] prod5;
	logic [22:0] prod7;

	assign prod3 = {10'd0, num} * {11'd0, RECIP3};
	assign prod5 = {11'd0, num} * {11'd0, RECIP5};
	assign prod7 = {12'd0, num} * {11'd0, RECIP7};

	always_comb begin
		case (kind)
			DIV_3:    quot = prod3[18:11];
			DIV_5:    quot = prod5[20:13];
			DIV_7:    quot = prod7[21:14];
			DIV_NONE: quot = num[7:0];
			default:  quot = num[7:0];
		endcase
	end

endmodule

// ----- rtl/dxt_texel_decoder_top.sv -----
// top level of the dxt1/dxt3/dxt5 single texel decoder, three-stage pipeline
// depends on dxt_pkg and dxt_recip_div
//
// a transaction passes through the s1, s2 and s3 registers on its way to argb
// throughput: one texel per cycle; every stage holds under output back-pressure
// s3 is the output register, so a new transaction enters while a result waits
// reset: arst_n clears only the stage valid bits; payload registers are not reset
module dxt_texel_decoder_top import dxt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [15:0] color_endpoint0,
	input  logic [15:0] color_endpoint1,
	input  logic [31:0] color_indices,
	input  logic [63:0] alpha_block,
	input  logic [1:0]  texel_col,
	input  logic [1:0]  texel_row,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] argb
);

	// stage valid bits and advance enables
	logic v_s1, v_s2, v_s3;
	logic ready_s1, ready_s2, ready_s3;

	assign ready_s3 = !v_s3 || out_ready;
	assign ready_s2 = !v_s2 || ready_s3;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready_s1) v_s1 <= in_valid;
			if (ready_s2) v_s2 <= v_s1;
			if (ready_s3) v_s3 <= v_s2;
		end
	end

	// ---------------------------------------------------------------
	// stage 1: pick the texel's fields out of the block
	// ---------------------------------------------------------------
	logic [5:0] code_pos;
	logic [3:0] texel_idx;

	assign texel_idx = {texel_row, texel_col};
	// alpha code of texel t sits at bit 16 + 3t
	assign code_pos  = 6'd16 + {2'b00, texel_idx} + {1'b0, texel_idx, 1'b0};

	logic [1:0]  mode_s1;
	logic [15:0] e0_s1, e1_s1;
	logic [1:0]  sel_s1;
	logic [3:0]  nib_s1;
	logic [2:0]  code_s1;
	logic [7:0]  a0_s1, a1_s1;

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			mode_s1 <= mode;
			e0_s1   <= color_endpoint0;
			e1_s1   <= color_endpoint1;
			sel_s1  <= color_indices[{texel_row, texel_col, 1'b0} +: 2];
			nib_s1  <= alpha_block[{texel_row, texel_col, 2'b00} +: 4];
			code_s1 <= alpha_block[code_pos +: 3];
			a0_s1   <= alpha_block[7:0];
			a1_s1   <= alpha_block[15:8];
		end
	end

	// ---------------------------------------------------------------
	// stage 2: expand endpoints, build palette numerators
	// ---------------------------------------------------------------
	logic [7:0]  c0 [3];
	logic [7:0]  c1 [3];
	logic        four_color;
	logic        transp;
	logic [9:0]  ch_num [3];
	logic        ch_div3;
	logic [10:0] alpha_num;
	div_kind_t   alpha_div;
	logic [2:0]  w0, w1;
	logic [10:0] p0, p1;

	// channel 0 red, 1 green, 2 blue
	assign c0[0] = expand5(e0_s1[15:11]);
	assign c0[1] = expand6(e0_s1[10:5]);
	assign c0[2] = expand5(e0_s1[4:0]);
	assign c1[0] = expand5(e1_s1[15:11]);
	assign c1[1] = expand6(e1_s1[10:5]);
	assign c1[2] = expand5(e1_s1[4:0]);

	assign four_color = e0_s1 > e1_s1;
	// fourth entry of the three-colour palette is transparent black
	assign transp     = !four_color && (sel_s1 == 2'd3);
	assign ch_div3    = four_color && sel_s1[1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			case (sel_s1)
				2'd0: ch_num[i] = {2'b00, c0[i]};
				2'd1: ch_num[i] = {2'b00, c1[i]};
				2'd2: begin
					if (four_color)
						ch_num[i] = {1'b0, c0[i], 1'b0} + {2'b00, c1[i]} + 10'd1;
					else
						ch_num[i] = 10'(({1'b0, c0[i]} + {1'b0, c1[i]}) >> 1);
				end
				2'd3: begin
					if (four_color)
						ch_num[i] = {2'b00, c0[i]} + {1'b0, c1[i], 1'b0} + 10'd1;
					else
						ch_num[i] = 10'd0;
				end
				default: ch_num[i] = 10'd0;
			endcase
		end
	end

	// interpolation weights for the alpha palette
	always_comb begin
		w1 = code_s1 - 3'd1;
		if (a0_s1 > a1_s1)
			w0 = 3'(4'd8 - {1'b0, code_s1});
		else
			w0 = 3'd6 - code_s1;
	end

	assign p0 = {8'd0, w0} * {3'd0, a0_s1};
	assign p1 = {8'd0, w1} * {3'd0, a1_s1};

	always_comb begin
		alpha_num = 11'd0;
		alpha_div = DIV_NONE;
		case (mode_s1)
			MODE_DXT3: alpha_num = {3'd0, nib_s1, nib_s1};
			MODE_DXT5: begin
				if (code_s1 == 3'd0)
					alpha_num = {3'd0, a0_s1};
				else if (code_s1 == 3'd1)
					alpha_num = {3'd0, a1_s1};
				else if (a0_s1 > a1_s1) begin
					alpha_num = p0 + p1 + 11'd3;
					alpha_div = DIV_7;
				end else if (code_s1 == 3'd6)
					alpha_num = 11'd0;
				else if (code_s1 == 3'd7)
					alpha_num = 11'd255;
				else begin
					alpha_num = p0 + p1 + 11'd2;
					alpha_div = DIV_5;
				end
			end
			// dxt1 and the unused code take alpha from the palette entry
			default: alpha_num = transp ? 11'd0 : 11'd255;
		endcase
	end

	logic [9:0]  ch_num_s2 [3];
	logic        ch_div3_s2;
	logic [10:0] alpha_num_s2;
	div_kind_t   alpha_div_s2;

	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			ch_num_s2    <= ch_num;
			ch_div3_s2   <= ch_div3;
			alpha_num_s2 <= alpha_num;
			alpha_div_s2 <= alpha_div;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: reciprocal divides, pack into the output register
	// ---------------------------------------------------------------
	logic [7:0] ch_q [3];
	logic [7:0] alpha_q;
	div_kind_t  ch_kind;

	assign ch_kind = ch_div3_s2 ? DIV_3 : DIV_NONE;

	for (genvar g = 0; g < 3; g++) begin : g_chan
		dxt_recip_div u_div (
			.num  ({1'b0, ch_num_s2[g]}),
			.kind (ch_kind),
			.quot (ch_q[g])
		);
	end

	dxt_recip_div u_alpha_div (
		.num  (alpha_num_s2),
		.kind (alpha_div_s2),
		.quot (alpha_q)
	);

	logic [31:0] argb_s3;

	always_ff @(posedge clk) begin
		if (ready_s3 && v_s2)
			argb_s3 <= {alpha_q, ch_q[0], ch_q[1], ch_q[2]};
	end

	assign out_valid = v_s3;
	assign argb      = argb_s3;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	// an accepted transaction always lands in s1
	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted transaction lost at s1");

	// an item leaving s1 always lands in s2
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && ready_s2) |=> v_s2)
		else $error("item lost between s1 and s2");

	// a stalled s2 keeps its payload until s3 frees up
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !ready_s3) |=> (v_s2 && $stable(alpha_num_s2) && $stable(ch_div3_s2)))
		else $error("s2 payload changed while stalled");

	// s3 is never overwritten while its result waits
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !out_ready && v_s2) |=> (v_s3 && v_s2))
		else $error("s3 result dropped under back-pressure");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// self-checking bench for dxt_texel_decoder_top: directed and random texel transactions
// depends on dxt_pkg (mode codes) and the decoder rtl; expected texels are computed in-bench

module tb;
	import dxt_pkg::*;

	// the fourth mode code decodes as dxt1
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// palette select codes of the 2-bit colour index
	localparam logic [1:0] SEL_C0   = 2'd0;
	localparam logic [1:0] SEL_C1   = 2'd1;
	localparam logic [1:0] SEL_MID  = 2'd2;

	// dxt5 alpha codes with fixed meaning
	localparam int unsigned ACODE_A0   = 0;
	localparam int unsigned ACODE_A1   = 1;
	localparam int unsigned ACODE_ZERO = 6;
	localparam int unsigned ACODE_FULL = 7;

	localparam int RANDOM_TEXELS = 800;

	typedef struct {
		logic [1:0]  mode;
		logic [15:0] endpoint0;
		logic [15:0] endpoint1;
		logic [31:0] indices;
		logic [63:0] alpha;
		logic [1:0]  col;
		logic [1:0]  row;
		bit          drain_first;  // hold this one back until all texels are out
	} texel_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = '0;
	logic [15:0] color_endpoint0 = '0;
	logic [15:0] color_endpoint1 = '0;
	logic [31:0] color_indices = '0;
	logic [63:0] alpha_block = '0;
	logic [1:0]  texel_col = '0;
	logic [1:0]  texel_row = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] argb;

	texel_req_t  pending_q[$];
	logic [31:0] texel_expect_q[$];
	int          err_count = 0;
	bit          idle_on = 1'b1;

	// driver side
	texel_req_t  cur_req;
	int          tx_gap = 0;
	bit          tx_offer;

	// monitor side
	int          rx_count = 0;
	int          rx_stall = 0;
	int          rx_hold = 0;
	bit          hold_done = 1'b0;
	bit          rx_rdy;
	logic [31:0] want;

	dxt_texel_decoder_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (mode),
		.color_endpoint0 (color_endpoint0),
		.color_endpoint1 (color_endpoint1),
		.color_indices   (color_indices),
		.alpha_block     (alpha_block),
		.texel_col       (texel_col),
		.texel_row       (texel_row),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.argb            (argb)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// n-bit channel to 8 bits, truncating
	function automatic int unsigned scale_bits(int unsigned v, int unsigned full);
		return v * 255 / full;
	endfunction

	// expected argb of one texel transaction
	function automatic logic [31:0] predict_texel(texel_req_t q);
		int unsigned r0, g0, b0, r1, g1, b1, r, g, b, al, a0, a1, code, t;
		logic [1:0]  sel;
		bit          four;
		sel = q.indices[8 * q.row + 2 * q.col +: 2];
		r0 = scale_bits(q.endpoint0[15:11], 31);
		g0 = scale_bits(q.endpoint0[10:5], 63);
		b0 = scale_bits(q.endpoint0[4:0], 31);
		r1 = scale_bits(q.endpoint1[15:11], 31);
		g1 = scale_bits(q.endpoint1[10:5], 63);
		b1 = scale_bits(q.endpoint1[4:0], 31);
		four = q.endpoint0 > q.endpoint1;
		al = 255;
		case (sel)
			SEL_C0: begin
				r = r0; g = g0; b = b0;
			end
			SEL_C1: begin
				r = r1; g = g1; b = b1;
			end
			SEL_MID: begin
				if (four) begin
					r = (2 * r0 + r1 + 1) / 3;
					g = (2 * g0 + g1 + 1) / 3;
					b = (2 * b0 + b1 + 1) / 3;
				end else begin
					r = (r0 + r1) / 2;
					g = (g0 + g1) / 2;
					b = (b0 + b1) / 2;
				end
			end
			default: begin
				if (four) begin
					r = (r0 + 2 * r1 + 1) / 3;
					g = (g0 + 2 * g1 + 1) / 3;
					b = (b0 + 2 * b1 + 1) / 3;
				end else begin
					// transparent black
					r = 0; g = 0; b = 0; al = 0;
				end
			end
		endcase
		case (q.mode)
			MODE_DXT3: al = scale_bits(q.alpha[16 * q.row + 4 * q.col +: 4], 15);
			MODE_DXT5: begin
				a0 = q.alpha[7:0];
				a1 = q.alpha[15:8];
				t = 4 * q.row + q.col;
				code = q.alpha[16 + 3 * t +: 3];
				if (code == ACODE_A0)
					al = a0;
				else if (code == ACODE_A1)
					al = a1;
				else if (a0 > a1)
					al = ((8 - code) * a0 + (code - 1) * a1 + 3) / 7;
				else if (code == ACODE_ZERO)
					al = 0;
				else if (code == ACODE_FULL)
					al = 255;
				else
					al = ((6 - code) * a0 + (code - 1) * a1 + 2) / 5;
			end
			default: ;
		endcase
		return {al[7:0], r[7:0], g[7:0], b[7:0]};
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
		err_count++;
		if (err_count <= 100)
			$display("[%0t] %s: argb %08h, expected %08h", $time, what, got, exp_val);
	endtask

	task automatic add_texel(logic [1:0] m, logic [15:0] e0, logic [15:0] e1,
			logic [31:0] idx, logic [63:0] ab, logic [1:0] c, logic [1:0] r, bit drain);
		texel_req_t q;
		q.mode = m;
		q.endpoint0 = e0;
		q.endpoint1 = e1;
		q.indices = idx;
		q.alpha = ab;
		q.col = c;
		q.row = r;
		q.drain_first = drain;
		pending_q.push_back(q);
	endtask

	// driver: holds the payload while a transaction waits, otherwise picks
	// the next item, an idle burst, or waits out a drain request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (in_valid && in_ready)
				texel_expect_q.push_back(predict_texel(cur_req));
			if (!(in_valid && !in_ready)) begin
				tx_offer = 1'b0;
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (pending_q.size() != 0) begin
					if (pending_q[0].drain_first && texel_expect_q.size() != 0) begin
						// pipeline still busy: stay idle until it is empty
					end else if (idle_on && rx_hold == 0 && $urandom_range(0, 7) == 0) begin
						// start an idle burst; tx_gap holds its random remaining length
						tx_gap = $urandom_range(0, 15);
					end else begin
						cur_req = pending_q.pop_front();
						tx_offer = 1'b1;
					end
				end
				in_valid <= tx_offer;
				if (tx_offer) begin
					mode <= cur_req.mode;
					color_endpoint0 <= cur_req.endpoint0;
					color_endpoint1 <= cur_req.endpoint1;
					color_indices <= cur_req.indices;
					alpha_block <= cur_req.alpha;
					texel_col <= cur_req.col;
					texel_row <= cur_req.row;
				end
			end
		end
	end

	// monitor: checks each result transaction against the oldest expected texel
	// and shapes out_ready with random stalls and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				rx_count++;
				if (texel_expect_q.size() == 0) begin
					report_mismatch("unexpected texel", argb, 'x);
				end else begin
					want = texel_expect_q.pop_front();
					if (argb !== want)
						report_mismatch("texel mismatch", argb, want);
				end
			end
			// long hold-off once, early enough that the sender still has work,
			// so the pipeline fills and in_ready drops
			if (!hold_done && rx_count >= 150) begin
				rx_hold = 80;
				hold_done = 1'b1;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				rx_rdy = 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				rx_rdy = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				rx_stall = $urandom_range(0, 15);
				rx_rdy = 1'b0;
			end else begin
				rx_rdy = 1'b1;
			end
			out_ready <= rx_rdy;
		end
	end

	// stimulus, reset and end of run
	initial begin
		logic [63:0] ab;
		logic [1:0]  m;
		logic [15:0] e0, e1;
		int          k, sel_m;

		// directed: palette extremes, both palettes, transparent entry, unused mode
		add_texel(MODE_DXT1, 16'hFFFF, 16'h0000, 32'h0000_0000, 64'h0, 2'd0, 2'd0, 1'b0);
		add_texel(MODE_DXT1, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 64'h0, 2'd3, 2'd3, 1'b0);
		add_texel(MODE_DXT1, 16'h0000, 16'hFFFF, 32'hAAAA_AAAA, 64'h0, 2'd1, 2'd2, 1'b0);
		add_texel(MODE_DXT1, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			2'd2, 2'd1, 1'b0);
		add_texel(MODE_DXT1, 16'h1234, 16'h1234, 32'hFFFF_FFFF, 64'h0, 2'd0, 2'd3, 1'b0);
		add_texel(MODE_UNUSED, 16'hF800, 16'h07E0, 32'hAAAA_AAAA, 64'hFFFF_FFFF_FFFF_FFFF,
			2'd3, 2'd0, 1'b0);
		add_texel(MODE_DXT3, 16'h07E0, 16'h001F, 32'h5555_5555, 64'hFFFF_FFFF_FFFF_FFFF,
			2'd3, 2'd3, 1'b0);
		add_texel(MODE_DXT3, 16'h001F, 16'hF800, 32'hFFFF_FFFF, 64'h0, 2'd0, 2'd0, 1'b0);
		// transparent entry keeps zero colour but takes the explicit alpha
		add_texel(MODE_DXT3, 16'h001F, 16'hF800, 32'hFFFF_FFFF, 64'h8765_4321_FEDC_BA98,
			2'd2, 2'd1, 1'b0);

		// dxt5: texel t carries alpha code t mod 8, so both palettes see every code
		ab = '0;
		for (k = 0; k < 16; k++)
			ab[16 + 3 * k +: 3] = 3'(k % 8);
		ab[15:0] = {8'd10, 8'd200};
		for (k = 0; k < 8; k++)
			add_texel(MODE_DXT5, 16'hFFFF, 16'h0000, 32'h1B1B_1B1B, ab, 2'(k % 4), 2'(k / 4),
				1'b0);
		ab[15:0] = {8'd200, 8'd10};
		for (k = 8; k < 16; k++)
			add_texel(MODE_DXT5, 16'h0000, 16'hFFFF, 32'hE4E4_E4E4, ab, 2'(k % 4), 2'(k / 4),
				1'b0);
		ab[15:0] = {8'd0, 8'd255};
		add_texel(MODE_DXT5, 16'hABCD, 16'h1234, 32'h0, ab, 2'd2, 2'd0, 1'b0);
		ab[15:0] = {8'd77, 8'd77};
		add_texel(MODE_DXT5, 16'hABCD, 16'h1234, 32'h0, ab, 2'd3, 2'd0, 1'b0);

		// random: all modes, full-width payloads, with equal endpoints and equal
		// alpha levels forced now and then; drain before the first and the middle one
		for (k = 0; k < RANDOM_TEXELS; k++) begin
			sel_m = $urandom_range(0, 9);
			if (sel_m < 3)
				m = MODE_DXT1;
			else if (sel_m < 6)
				m = MODE_DXT3;
			else if (sel_m < 9)
				m = MODE_DXT5;
			else
				m = MODE_UNUSED;
			e0 = 16'($urandom);
			e1 = ($urandom_range(0, 7) == 0) ? e0 : 16'($urandom);
			ab = {$urandom, $urandom};
			if ($urandom_range(0, 7) == 0)
				ab[15:8] = ab[7:0];
			add_texel(m, e0, e1, $urandom, ab, 2'($urandom), 2'($urandom),
				k == 0 || k == RANDOM_TEXELS / 2);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// no idling over the last stretch
		while (pending_q.size() > 100)
			@(posedge clk);
		idle_on = 1'b0;

		while (pending_q.size() != 0 || in_valid || texel_expect_q.size() != 0)
			@(posedge clk);
		// pipeline is three deep; catch any stray result after the last one
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule
